[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[sv/nps_pkg.sv]
// Package with constants and types for the nearest point search unit.
package nps_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int POINT_BITS = 2 * COORD_BITS;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int DIST_BITS  = SQ_BITS + 1;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic [IDX_BITS-1:0] idx;
  } tag_t;

endpackage

[sv/nps_point_mem.sv]
// Point table memory: one write port, one registered read port.
module nps_point_mem
  import nps_pkg::*;
(
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IDX_BITS-1:0]   wr_addr,
  input  logic [POINT_BITS-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [IDX_BITS-1:0]   rd_addr,
  output logic [POINT_BITS-1:0] rd_data
);

  logic [POINT_BITS-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/nps_dist_unit.sv]
// Pipelined squared-distance unit with running minimum over a scan.
module nps_dist_unit
  import nps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] qx,
  input  logic [COORD_BITS-1:0] qy,
  input  logic [POINT_BITS-1:0] point,
  input  tag_t                  tag_in,
  output logic                  done,
  output logic [DIST_BITS-1:0]  best_dist,
  output logic [IDX_BITS-1:0]   best_idx
);

  logic [COORD_BITS-1:0] px, py;
  logic [COORD_BITS-1:0] dx, dy;
  logic [SQ_BITS-1:0]    sqx, sqy;
  logic [DIST_BITS-1:0]  sum;
  tag_t                  a_tag, b_tag;
  logic                  have;

  assign px  = point[COORD_BITS-1:0];
  assign py  = point[POINT_BITS-1:COORD_BITS];
  assign sum = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    dx  <= (px >= qx) ? px - qx : qx - px;
    dy  <= (py >= qy) ? py - qy : qy - py;
    sqx <= dx * dx;
    sqy <= dy * dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
      b_tag <= '0;
      done  <= 1'b0;
      have  <= 1'b0;
    end else begin
      a_tag <= tag_in;
      b_tag <= a_tag;
      done  <= b_tag.valid && b_tag.last;
      if (start) begin
        have <= 1'b0;
      end else if (b_tag.valid) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_tag.valid && (!have || sum < best_dist)) begin
      best_dist <= sum;
      best_idx  <= b_tag.idx;
    end
  end

endmodule

[sv/nearest_point_search_unit.sv]
// Top level of the nearest point search unit: sequencer, table and output register.
//
// Input channel (in_valid, in_stall): func selects append (0) or query (1);
// x_coord and y_coord carry the point or query position. in_stall is low
// only while the unit is idle, so one item is in work at a time.
// Output channel (out_valid, out_stall): one result item per input item with
// status, nearest_index and nearest_dist_sq. The result sits in an output
// register, so the next input item is taken while it still waits.
// An append, a full-table append or a query on an empty table goes straight to
// the result state. A query over N stored points issues one table read per
// cycle into a 4-stage read/difference/square/compare pipeline, and the
// sequencer waits for the last compare before it enters the result state.
// The result state loads the output register and raises out_valid once that
// register is free; only then is a new input item taken.
// Reset (rst, synchronous) empties the table and clears all valid state.
// When the receiver stalls, the result holds; a finished item waits in the
// sequencer until the output register frees.
module nearest_point_search_unit
  import nps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [COORD_BITS-1:0] x_coord,
  input  logic [COORD_BITS-1:0] y_coord,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [5:0]            nearest_index,
  output logic [32:0]           nearest_dist_sq
);

  `include "assert_macros.svh"

  state_t                state, state_next;
  logic [CNT_BITS-1:0]   entry_count;
  logic [IDX_BITS-1:0]   iss_idx;
  logic [COORD_BITS-1:0] qx, qy;
  tag_t                  mem_tag;
  logic [POINT_BITS-1:0] rd_data;
  status_t               res_status;
  logic [IDX_BITS-1:0]   res_idx;
  logic [DIST_BITS-1:0]  res_dist;
  logic                  dist_done;
  logic [DIST_BITS-1:0]  best_dist;
  logic [IDX_BITS-1:0]   best_idx;
  logic                  in_take, out_take, out_load, is_last, full, wr_en;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign full     = entry_count == CNT_BITS'(MAX_POINTS);
  assign is_last  = (CNT_BITS'(iss_idx) + CNT_BITS'(1)) == entry_count;
  assign wr_en    = in_take && func == FUNC_APPEND && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = (func == FUNC_QUERY && entry_count != '0) ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (is_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (dist_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      mem_tag     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_count <= entry_count + CNT_BITS'(1);
      end
      mem_tag.valid <= state == ST_SCAN;
      mem_tag.last  <= is_last;
      mem_tag.idx   <= iss_idx;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      qx       <= x_coord;
      qy       <= y_coord;
      iss_idx  <= '0;
      res_dist <= '0;
      if (func == FUNC_APPEND) begin
        res_status <= full ? STATUS_FULL : STATUS_OK;
        res_idx    <= full ? '0 : entry_count[IDX_BITS-1:0];
      end else begin
        res_status <= (entry_count == '0) ? STATUS_EMPTY : STATUS_OK;
        res_idx    <= '0;
      end
    end else if (state == ST_SCAN) begin
      iss_idx <= iss_idx + IDX_BITS'(1);
    end else if (state == ST_WAIT && dist_done) begin
      res_idx  <= best_idx;
      res_dist <= best_dist;
    end
    if (out_load) begin
      status          <= res_status;
      nearest_index   <= res_idx;
      nearest_dist_sq <= res_dist;
    end
  end

  nps_point_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count[IDX_BITS-1:0]),
    .wr_data ({y_coord, x_coord}),
    .rd_en   (state == ST_SCAN),
    .rd_addr (iss_idx),
    .rd_data (rd_data)
  );

  nps_dist_unit u_dist (
    .clk       (clk),
    .rst       (rst),
    .start     (in_take),
    .qx        (qx),
    .qy        (qy),
    .point     (rd_data),
    .tag_in    (mem_tag),
    .done      (dist_done),
    .best_dist (best_dist),
    .best_idx  (best_idx)
  );

  `ASSERT_IMPL(a_count_range, clk, rst, 1'b1, entry_count <= CNT_BITS'(MAX_POINTS))
  `ASSERT_NEXT(a_query_scans, clk, rst, in_take && func == FUNC_QUERY && entry_count != '0, state == ST_SCAN)
  `ASSERT_IMPL(a_done_in_wait, clk, rst, dist_done, state == ST_WAIT)
  `ASSERT_IMPL(a_ok_index, clk, rst, out_valid && status == STATUS_OK, CNT_BITS'(nearest_index) < entry_count)

endmodule
